// ===== src/mlfd_pkg.sv =====
// Shared types, constants and magic-word table for the magic/length deframer.
package mlfd_pkg;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_TYPE = 2'd1,
      PH_LEN  = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   localparam logic [7:0] MAGIC_NOW_0 = 8'hC1;
   localparam logic [7:0] MAGIC_NOW_1 = 8'h1F;
   localparam logic [7:0] MAGIC_NOW_2 = 8'hFE;
   localparam logic [7:0] MAGIC_NOW_3 = 8'h72;
   localparam logic [7:0] MAGIC_OLD_0 = 8'h53;
   localparam logic [7:0] MAGIC_OLD_1 = 8'h6E;
   localparam logic [7:0] MAGIC_OLD_2 = 8'h69;
   localparam logic [7:0] MAGIC_OLD_3 = 8'h66;
   localparam logic [8:0] CHECK_TAIL  = 9'd2;

   // Item held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } in_item_type;

   function automatic logic [7:0] magic_byte(input logic legacy, input logic [1:0] pos);
      logic [7:0] val;
      begin
         case (pos)
            2'd0: val = legacy ? MAGIC_OLD_0 : MAGIC_NOW_0;
            2'd1: val = legacy ? MAGIC_OLD_1 : MAGIC_NOW_1;
            2'd2: val = legacy ? MAGIC_OLD_2 : MAGIC_NOW_2;
            2'd3: val = legacy ? MAGIC_OLD_3 : MAGIC_NOW_3;
            default: val = MAGIC_NOW_0;
         endcase
         return val;
      end
   endfunction

endpackage

// ===== src/mlfd_in_stage.sv =====
// Input register: captures one received byte per handshake.
module mlfd_in_stage import mlfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        take,
   output in_item_type item
);

   in_item_type item_ff;
   in_item_type item_in;

   assign req_ready = !item_ff.valid || take;
   assign item      = item_ff;

   always_comb begin
      item_in = item_ff;
      if (req_ready) begin
         item_in.valid   = req_valid;
         item_in.rx_byte = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.rx_byte <= item_in.rx_byte;
   end

endmodule

// ===== src/mlfd_core.sv =====
// Deframer state machine and result register.
module mlfd_core import mlfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  in_item_type item,
   output logic        take,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_byte_index,
   output logic [7:0]  rsp_frame_kind,
   output logic        rsp_legacy_frame,
   output logic        rsp_check_byte,
   output logic        rsp_frame_last
);

   phase_type  phase_ff, phase_in;
   logic [1:0] match_ff, match_in;
   logic       legacy_ff, legacy_in;
   logic [7:0] kind_ff, kind_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] count_ff, count_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_data_ff, out_data_in;
   logic [7:0] out_index_ff, out_index_in;
   logic [7:0] out_kind_ff, out_kind_in;
   logic       out_legacy_ff, out_legacy_in;
   logic       out_check_ff, out_check_in;
   logic       out_last_ff, out_last_in;

   logic [7:0] b;
   logic [2:0] match_next;
   logic       last;
   logic       check;

   assign take = item.valid && (!out_valid_ff || rsp_ready);
   assign b    = item.rx_byte;
   assign last  = ({1'b0, count_ff} + 9'd1) >= {1'b0, length_ff};
   assign check = ({1'b0, count_ff} + CHECK_TAIL) >= {1'b0, length_ff};

   always_comb begin
      phase_in      = phase_ff;
      match_in      = match_ff;
      legacy_in     = legacy_ff;
      kind_in       = kind_ff;
      length_in     = length_ff;
      count_in      = count_ff;
      match_next    = {1'b0, match_ff};
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_data_in   = out_data_ff;
      out_index_in  = out_index_ff;
      out_kind_in   = out_kind_ff;
      out_legacy_in = out_legacy_ff;
      out_check_in  = out_check_ff;
      out_last_in   = out_last_ff;
      if (take) begin
         case (phase_ff)
            PH_HUNT: begin
               if (match_ff == 2'd0) begin
                  if (b == MAGIC_NOW_0) begin
                     match_next = 3'd1;
                     legacy_in  = 1'b0;
                  end else if (b == MAGIC_OLD_0) begin
                     match_next = 3'd1;
                     legacy_in  = 1'b1;
                  end else begin
                     legacy_in  = 1'b0;
                  end
               end else if (b != magic_byte(legacy_ff, match_ff)) begin
                  // Mismatch: restart the hunt, drop the legacy flag
                  match_next = 3'd0;
                  legacy_in  = 1'b0;
               end else begin
                  match_next = {1'b0, match_ff} + 3'd1;
               end
               match_in = match_next[1:0];
               if (match_next[2]) begin
                  if (legacy_in) begin
                     kind_in  = 8'd0;
                     phase_in = PH_LEN;
                  end else begin
                     phase_in = PH_TYPE;
                  end
               end
            end
            PH_TYPE: begin
               kind_in  = b;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               length_in = b;
               count_in  = 8'd0;
               if (b == 8'd0) begin
                  phase_in  = PH_HUNT;
                  match_in  = 2'd0;
                  legacy_in = 1'b0;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               out_valid_in  = 1'b1;
               out_data_in   = b;
               out_index_in  = count_ff;
               out_kind_in   = kind_ff;
               out_legacy_in = legacy_ff;
               out_check_in  = check;
               out_last_in   = last;
               if (last) begin
                  count_in  = 8'd0;
                  phase_in  = PH_HUNT;
                  match_in  = 2'd0;
                  legacy_in = 1'b0;
               end else begin
                  count_in = count_ff + 8'd1;
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         match_ff     <= 2'd0;
         legacy_ff    <= 1'b0;
         kind_ff      <= 8'd0;
         length_ff    <= 8'd0;
         count_ff     <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         match_ff     <= match_in;
         legacy_ff    <= legacy_in;
         kind_ff      <= kind_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff   <= out_data_in;
      out_index_ff  <= out_index_in;
      out_kind_ff   <= out_kind_in;
      out_legacy_ff <= out_legacy_in;
      out_check_ff  <= out_check_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_data_byte    = out_data_ff;
   assign rsp_byte_index   = out_index_ff;
   assign rsp_frame_kind   = out_kind_ff;
   assign rsp_legacy_frame = out_legacy_ff;
   assign rsp_check_byte   = out_check_ff;
   assign rsp_frame_last   = out_last_ff;

endmodule

// ===== src/magic_length_frame_deframer.sv =====
// Top level of the magic-word, length-prefixed byte deframer.
// Bytes enter on req_ one per cycle while req_ready is high, pass through an input
// register and then the framing state machine, which fills the rsp_ result register;
// one item per cycle is sustained as long as rsp_ready stays high. The block hunts
// for C1 1F FE 72 (then type byte) or 53 6E 69 66 (legacy, type reads as zero), then
// takes a length byte and emits that many data bytes, each with its index, frame
// type, legacy flag, check mark (last two bytes) and last mark.
// A wrong magic byte restarts the hunt; a zero length emits nothing.
module magic_length_frame_deframer import mlfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_byte_index,
   output logic [7:0] rsp_frame_kind,
   output logic       rsp_legacy_frame,
   output logic       rsp_check_byte,
   output logic       rsp_frame_last
);

   in_item_type item;
   logic        take;

   mlfd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .take        (take),
      .item        (item)
   );

   mlfd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .item             (item),
      .take             (take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_kind   (rsp_frame_kind),
      .rsp_legacy_frame (rsp_legacy_frame),
      .rsp_check_byte   (rsp_check_byte),
      .rsp_frame_last   (rsp_frame_last)
   );

endmodule
